// File: hdl/force_free_e_field_correction_assert.svh
// Assertion macros for the force-free field correction block.
// No dependencies; included by the top level.
`ifndef FORCE_FREE_E_FIELD_CORRECTION_ASSERT_SVH
`define FORCE_FREE_E_FIELD_CORRECTION_ASSERT_SVH

// same-cycle implication
`define FFC_ASSERT_IMP(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define FFC_ASSERT_NXT(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/ffc_pkg.sv
// Shared constants and types for the force-free field correction block.
// No dependencies.
`default_nettype none

package ffc_pkg;
  localparam int LANES      = 3;
  localparam int SCALE_BITS = 31;
  localparam int RATIO_BITS = 2 * SCALE_BITS;

  typedef struct packed {
    logic was_scaled;
    logic null_field;
  } flags_t;
endpackage

`default_nettype wire

// File: hdl/ffc_project.sv
// Removes the component of E parallel to B: dot products, pipelined
// quotient and fractional division, correction. Depends on ffc_pkg.
`default_nettype none

module ffc_project #(
  parameter int W = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_v,
  input  logic [ffc_pkg::LANES-1:0][W-1:0]     b,
  input  logic [ffc_pkg::LANES-1:0][W-1:0]     e,
  output logic                                 out_v,
  output logic [ffc_pkg::LANES-1:0][W+1:0]     ec,
  output logic [2*W+1:0]                       bb,
  output logic                                 nul
);
  import ffc_pkg::*;

  localparam int PW = 2 * W + 2;
  localparam int QB = W + 1;
  localparam int EW = W + 2;
  localparam int NF = QB + W;

  typedef struct packed {
    logic [LANES-1:0][W-1:0]  e;
    logic [LANES-1:0][W-1:0]  mb;
    logic [LANES-1:0]         sb;
    logic [PW-1:0]            bb;
    logic [PW-1:0]            dot;
    logic                     dot_neg;
    logic                     nul;
    logic [PW-1:0]            r;
    logic [QB-1:0]            q;
    logic [LANES-1:0][PW-1:0] fr;
    logic [LANES-1:0][W-1:0]  ff;
  } item_t;

  logic                    s1_v, s2_v, s3_v;
  logic [W-1:0]            s1_mb [LANES];
  logic [W-1:0]            s1_me [LANES];
  logic [LANES-1:0]        s1_sb, s1_neg, s2_sb, s2_neg, s3_sb;
  logic [LANES-1:0][W-1:0] s1_e, s1_mbp, s2_e, s2_mb, s3_e, s3_mb;
  logic [2*W-1:0]          s2_pbb [LANES];
  logic [2*W-1:0]          s2_pbe [LANES];
  logic [PW-1:0]           s3_bb, s3_pos, s3_ng;

  item_t st  [0:NF];
  logic  vld [0:NF];

  always_comb begin
    for (int i = 0; i < LANES; i++) s1_mbp[i] = s1_mb[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        s1_mb[i]  <= b[i][W-1] ? (~b[i] + W'(1)) : b[i];
        s1_me[i]  <= e[i][W-1] ? (~e[i] + W'(1)) : e[i];
        s1_sb[i]  <= b[i][W-1];
        s1_neg[i] <= b[i][W-1] ^ e[i][W-1];
        s1_e[i]   <= e[i];
        s2_pbb[i] <= s1_mb[i] * s1_mb[i];
        s2_pbe[i] <= s1_mb[i] * s1_me[i];
      end
      s2_neg <= s1_neg;
      s2_sb  <= s1_sb;
      s2_e   <= s1_e;
      s2_mb  <= s1_mbp;
      s3_bb  <= PW'(s2_pbb[0]) + PW'(s2_pbb[1]) + PW'(s2_pbb[2]);
      s3_pos <= (s2_neg[0] ? '0 : PW'(s2_pbe[0])) + (s2_neg[1] ? '0 : PW'(s2_pbe[1]))
              + (s2_neg[2] ? '0 : PW'(s2_pbe[2]));
      s3_ng  <= (s2_neg[0] ? PW'(s2_pbe[0]) : '0) + (s2_neg[1] ? PW'(s2_pbe[1]) : '0)
              + (s2_neg[2] ? PW'(s2_pbe[2]) : '0);
      s3_sb  <= s2_sb;
      s3_e   <= s2_e;
      s3_mb  <= s2_mb;
    end
  end

  // signed dot product as magnitude and sign, seed of the divider
  item_t       d_nx;
  logic [PW:0] d_diff;
  logic [PW:0] d_rdiff;

  always_comb begin
    d_diff       = {1'b0, s3_pos} - {1'b0, s3_ng};
    d_rdiff      = {1'b0, s3_ng} - {1'b0, s3_pos};
    d_nx         = '0;
    d_nx.e       = s3_e;
    d_nx.mb      = s3_mb;
    d_nx.sb      = s3_sb;
    d_nx.bb      = s3_bb;
    d_nx.dot_neg = d_diff[PW];
    d_nx.dot     = d_diff[PW] ? d_rdiff[PW-1:0] : d_diff[PW-1:0];
    d_nx.nul     = (s3_bb == '0);
    d_nx.r       = d_nx.dot >> QB;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= s3_v;
    if (en) st[0] <= d_nx;
  end

  // quotient dot / bb, one bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    item_t       nx;
    logic [PW:0] t;
    logic        ge;
    always_comb begin
      nx   = st[k];
      t    = {st[k].r, st[k].dot[QB-1-k]};
      ge   = (t >= {1'b0, st[k].bb});
      nx.r = ge ? PW'(t - {1'b0, st[k].bb}) : t[PW-1:0];
      nx.q = {st[k].q[QB-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) st[k+1] <= nx;
    end
  end

  // floor(rem * |b| / bb), one bit of |b| per stage
  for (genvar j = 0; j < W; j++) begin : g_frac
    localparam int K = QB + j;
    item_t         nx;
    logic [PW+1:0] t  [LANES];
    logic [PW+1:0] b1, b2;
    always_comb begin
      nx = st[K];
      b1 = {2'b00, st[K].bb};
      b2 = {1'b0, st[K].bb, 1'b0};
      for (int i = 0; i < LANES; i++) begin
        t[i] = {1'b0, st[K].fr[i], 1'b0}
             + {2'b00, (st[K].mb[i][W-1-j] ? st[K].r : {PW{1'b0}})};
        if (t[i] >= b2) begin
          nx.fr[i] = PW'(t[i] - b2);
          nx.ff[i] = {st[K].ff[i][W-2:0], 1'b0} + W'(2);
        end else if (t[i] >= b1) begin
          nx.fr[i] = PW'(t[i] - b1);
          nx.ff[i] = {st[K].ff[i][W-2:0], 1'b0} + W'(1);
        end else begin
          nx.fr[i] = t[i][PW-1:0];
          nx.ff[i] = {st[K].ff[i][W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[K+1] <= 1'b0;
      else if (en) vld[K+1] <= vld[K];
      if (en) st[K+1] <= nx;
    end
  end

  logic             m_v;
  item_t            m_it;
  logic [QB+W-1:0]  m_prod [LANES];
  logic [QB-1:0]    n_c    [LANES];
  logic [EW-1:0]    n_ex   [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      m_v   <= vld[NF];
      out_v <= m_v;
    end
    if (en) begin
      m_it <= st[NF];
      for (int i = 0; i < LANES; i++) m_prod[i] <= st[NF].q * st[NF].mb[i];
      for (int i = 0; i < LANES; i++) begin
        if (m_it.nul) ec[i] <= n_ex[i];
        else if (m_it.dot_neg != m_it.sb[i]) ec[i] <= n_ex[i] + {1'b0, n_c[i]};
        else ec[i] <= n_ex[i] - {1'b0, n_c[i]};
      end
      bb  <= m_it.bb;
      nul <= m_it.nul;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      n_c[i]  = QB'(m_prod[i] + (QB+W)'(m_it.ff[i]));
      n_ex[i] = {{2{m_it.e[i][W-1]}}, m_it.e[i]};
    end
  end

endmodule

`default_nettype wire

// File: hdl/ffc_limit.sv
// Limits |E| to |B| when limit_en is set: energy sum, pipelined ratio division,
// square root, scaling and output saturation. Depends on ffc_pkg.
`default_nettype none

module ffc_limit #(
  parameter int W = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_v,
  input  logic [ffc_pkg::LANES-1:0][W+1:0] ec,
  input  logic [2*W+1:0]                   bb,
  input  logic                             nul,
  input  logic                             limit_en,
  output logic                             out_v,
  output logic [ffc_pkg::LANES-1:0][W-1:0] new_e,
  output ffc_pkg::flags_t                  flags
);
  import ffc_pkg::*;

  localparam int EW = W + 2;
  localparam int PW = 2 * W + 2;
  localparam int EE = 2 * EW + 2;
  localparam int RB = RATIO_BITS;
  localparam int SB = SCALE_BITS;
  localparam int SR = SB + 2;
  localparam int NS = RB + SB;

  typedef struct packed {
    logic [LANES-1:0][EW-1:0] me;
    logic [LANES-1:0]         sg;
    logic [LANES-1:0][EW-1:0] ec;
    logic [EE-1:0]            ee;
    logic                     over;
    logic                     nul;
    logic [EE-1:0]            rr;
    logic [RB-1:0]            ratio;
    logic [SR-1:0]            rem;
    logic [SB-1:0]            root;
  } item_t;

  logic                     l1_v, l2_v, l3_v;
  logic [LANES-1:0][EW-1:0] l1_me, l1_ec, l2_me, l2_ec, l3_me, l3_ec;
  logic [LANES-1:0]         l1_sg, l2_sg, l3_sg;
  logic [PW-1:0]            l1_bb, l2_bb, l3_bb;
  logic                     l1_nul, l2_nul, l3_nul;
  logic [2*EW-1:0]          l2_sq [LANES];
  logic [EE-1:0]            l3_ee;

  item_t st  [0:NS];
  logic  vld [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
      l2_v <= 1'b0;
      l3_v <= 1'b0;
    end else if (en) begin
      l1_v <= in_v;
      l2_v <= l1_v;
      l3_v <= l2_v;
    end
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        l1_me[i] <= ec[i][EW-1] ? (~ec[i] + EW'(1)) : ec[i];
        l1_sg[i] <= ec[i][EW-1];
        l2_sq[i] <= l1_me[i] * l1_me[i];
      end
      l1_ec  <= ec;
      l1_bb  <= bb;
      l1_nul <= nul;
      l2_me  <= l1_me;
      l2_sg  <= l1_sg;
      l2_ec  <= l1_ec;
      l2_bb  <= l1_bb;
      l2_nul <= l1_nul;
      l3_ee  <= EE'(l2_sq[0]) + EE'(l2_sq[1]) + EE'(l2_sq[2]);
      l3_me  <= l2_me;
      l3_sg  <= l2_sg;
      l3_ec  <= l2_ec;
      l3_bb  <= l2_bb;
      l3_nul <= l2_nul;
    end
  end

  item_t s_nx;

  always_comb begin
    s_nx      = '0;
    s_nx.me   = l3_me;
    s_nx.sg   = l3_sg;
    s_nx.ec   = l3_ec;
    s_nx.ee   = l3_ee;
    s_nx.nul  = l3_nul;
    s_nx.over = limit_en && !l3_nul && (l3_ee > EE'(l3_bb));
    s_nx.rr   = EE'(l3_bb);
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= l3_v;
    if (en) st[0] <= s_nx;
  end

  // ratio = floor(bb * 2^62 / ee), one bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_ratio
    item_t       nx;
    logic [EE:0] t;
    logic        ge;
    always_comb begin
      nx       = st[k];
      t        = {st[k].rr, 1'b0};
      ge       = (t >= {1'b0, st[k].ee});
      nx.rr    = ge ? EE'(t - {1'b0, st[k].ee}) : t[EE-1:0];
      nx.ratio = {st[k].ratio[RB-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) st[k+1] <= nx;
    end
  end

  // integer square root, one root bit per stage
  for (genvar k = 0; k < SB; k++) begin : g_sqrt
    localparam int K = RB + k;
    item_t         nx;
    logic [SR+1:0] t, trial;
    logic          ge;
    always_comb begin
      nx      = st[K];
      t       = {st[K].rem, st[K].ratio[RB-1-2*k -: 2]};
      trial   = (SR+2)'({st[K].root, 2'b01});
      ge      = (t >= trial);
      nx.rem  = ge ? SR'(t - trial) : t[SR-1:0];
      nx.root = {st[K].root[SB-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[K+1] <= 1'b0;
      else if (en) vld[K+1] <= vld[K];
      if (en) st[K+1] <= nx;
    end
  end

  logic            p_v;
  item_t           p_it;
  logic [EW+SB-1:0] p_prod [LANES];
  logic [EW-1:0]   f_mag  [LANES];
  logic [EW:0]     f_val  [LANES];
  logic [W-1:0]    f_sat  [LANES];
  logic [EW-W+1:0] f_top  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      f_mag[i] = EW'(p_prod[i] >> SB);
      if (!p_it.over) f_val[i] = {p_it.ec[i][EW-1], p_it.ec[i]};
      else if (p_it.sg[i]) f_val[i] = -{1'b0, f_mag[i]};
      else f_val[i] = {1'b0, f_mag[i]};
      f_top[i] = f_val[i][EW:W-1];
      if (f_top[i] == '0 || f_top[i] == '1) f_sat[i] = f_val[i][W-1:0];
      else if (f_val[i][EW]) f_sat[i] = {1'b1, {(W-1){1'b0}}};
      else f_sat[i] = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      p_v   <= vld[NS];
      out_v <= p_v;
    end
    if (en) begin
      p_it <= st[NS];
      for (int i = 0; i < LANES; i++) begin
        p_prod[i] <= st[NS].me[i] * st[NS].root;
        new_e[i]  <= f_sat[i];
      end
      flags.was_scaled <= p_it.over;
      flags.null_field <= p_it.nul;
    end
  end

endmodule

`default_nettype wire

// File: hdl/force_free_e_field_correction.sv
// Force-free electric field correction: top level with output skid stage
// and configuration register. Depends on ffc_pkg, ffc_project, ffc_limit.
//
// Input channel in_valid/in_ready carries one cell (b_x..b_z, e_x..e_z,
// signed fixed point). Output channel out_valid/out_ready returns the
// corrected E, was_scaled and null_field, one transaction per input, in order.
// Configuration channel cfg_valid/cfg_ready writes limit_enable (always ready);
// write it only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled. The
// pipeline holds the bit-per-stage quotient and fraction dividers of the
// projection, the 62-stage ratio divider and the 31-stage square root.
// Reset (synchronous, active high) empties the pipeline and sets
// limit_enable to 1.
// When the receiver stalls, the last result drops into a one-entry skid
// register and the pipeline freezes; in_ready falls only while the skid
// register is occupied, so nothing is lost or repeated.
`default_nettype none

module force_free_e_field_correction #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] b_x,
  input  logic signed [DATA_WIDTH-1:0] b_y,
  input  logic signed [DATA_WIDTH-1:0] b_z,
  input  logic signed [DATA_WIDTH-1:0] e_x,
  input  logic signed [DATA_WIDTH-1:0] e_y,
  input  logic signed [DATA_WIDTH-1:0] e_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] new_e_x,
  output logic signed [DATA_WIDTH-1:0] new_e_y,
  output logic signed [DATA_WIDTH-1:0] new_e_z,
  output logic                         was_scaled,
  output logic                         null_field,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import ffc_pkg::*;

  localparam int W = DATA_WIDTH;

  logic                     en;
  logic                     limit_enable;
  logic [LANES-1:0][W-1:0]  b_in, e_in;
  logic                     pj_v;
  logic [LANES-1:0][W+1:0]  pj_ec;
  logic [2*W+1:0]           pj_bb;
  logic                     pj_nul;
  logic                     lm_v;
  logic [LANES-1:0][W-1:0]  lm_e;
  flags_t                   lm_flags;
  logic                     skid_full;
  logic [LANES-1:0][W-1:0]  skid_e;
  flags_t                   skid_flags;
  logic [LANES-1:0][W-1:0]  out_e;
  flags_t                   out_flags;

  assign b_in = {b_z, b_y, b_x};
  assign e_in = {e_z, e_y, e_x};

  assign en        = !skid_full;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) limit_enable <= 1'b1;
    else if (cfg_valid) limit_enable <= cfg_data;
  end

  ffc_project #(.W(W)) u_project (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (in_valid),
    .b     (b_in),
    .e     (e_in),
    .out_v (pj_v),
    .ec    (pj_ec),
    .bb    (pj_bb),
    .nul   (pj_nul)
  );

  ffc_limit #(.W(W)) u_limit (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (pj_v),
    .ec       (pj_ec),
    .bb       (pj_bb),
    .nul      (pj_nul),
    .limit_en (limit_enable),
    .out_v    (lm_v),
    .new_e    (lm_e),
    .flags    (lm_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) skid_full <= 1'b0;
    end else if (lm_v && !out_ready) begin
      skid_full <= 1'b1;
    end
    if (!skid_full) begin
      skid_e     <= lm_e;
      skid_flags <= lm_flags;
    end
  end

  assign out_valid  = skid_full || lm_v;
  assign out_e      = skid_full ? skid_e : lm_e;
  assign out_flags  = skid_full ? skid_flags : lm_flags;
  assign new_e_x    = out_e[0];
  assign new_e_y    = out_e[1];
  assign new_e_z    = out_e[2];
  assign was_scaled = out_flags.was_scaled;
  assign null_field = out_flags.null_field;

`include "force_free_e_field_correction_assert.svh"

  `FFC_ASSERT_NXT(a_skid_hold, clk, rst, skid_full && !out_ready, skid_full && $stable(skid_e), "skid entry lost")
  `FFC_ASSERT_IMP(a_flag_excl, clk, rst, out_valid, !(was_scaled && null_field), "scaled a null field")
  `FFC_ASSERT_IMP(a_limit_off, clk, rst, out_valid && !limit_enable, !was_scaled, "scaled with limit off")

endmodule

`default_nettype wire

// File: tb/ffc_checker.sv
// Checker for the force-free field correction block: watches the cell, result
// and limit-register channels, predicts each corrected E and compares it.
// Depends on nothing beyond the block's port widths (32-bit Q16.16).
module ffc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] e_x,
  input  logic signed [31:0] e_y,
  input  logic signed [31:0] e_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] new_e_x,
  input  logic signed [31:0] new_e_y,
  input  logic signed [31:0] new_e_z,
  input  logic               was_scaled,
  input  logic               null_field,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 errors,
  output int                 pending
);
  typedef struct {
    logic signed [31:0] ex, ey, ez;
    logic               scaled, nul;
  } field_t;

  field_t corrected_q[$];
  bit     limit_on;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic field_t correct_field(logic signed [31:0] bi[3], logic signed [31:0] ei[3],
                                           bit lim);
    logic signed [63:0] bv[3], ev[3];
    logic [127:0] bb, pos, neg, dot, ee, rr, prod, t;
    logic [63:0]  m, ratio, s, res, bit_v;
    bit           dneg;
    field_t       r;
    bb = 0; pos = 0; neg = 0;
    r.scaled = 0;
    for (int i = 0; i < 3; i++) begin
      bv[i] = bi[i];
      ev[i] = ei[i];
      prod = {64'd0, mag64(bv[i])} * {64'd0, mag64(ev[i])};
      bb += {64'd0, mag64(bv[i])} * {64'd0, mag64(bv[i])};
      if ((bv[i] < 0) != (ev[i] < 0)) neg += prod;
      else pos += prod;
    end
    r.nul = (bb == 0);
    if (!r.nul) begin
      dneg = neg > pos;
      dot = dneg ? neg - pos : pos - neg;
      for (int i = 0; i < 3; i++) begin
        m = mag64(bv[i]);
        if (m != 0 && dot != 0) begin
          t = (dot * {64'd0, m}) / bb;
          if (dneg != (bv[i] < 0)) ev[i] = ev[i] + $signed(t[63:0]);
          else ev[i] = ev[i] - $signed(t[63:0]);
        end
      end
      if (lim) begin
        ee = 0;
        for (int i = 0; i < 3; i++) ee += {64'd0, mag64(ev[i])} * {64'd0, mag64(ev[i])};
        if (ee > bb) begin
          rr = bb;
          ratio = 0;
          repeat (62) begin
            rr = {rr[126:0], 1'b0};
            ratio = ratio << 1;
            if (rr >= ee) begin
              rr = rr - ee;
              ratio = ratio | 64'd1;
            end
          end
          res = 0;
          bit_v = 64'd1 << 62;
          while (bit_v > ratio) bit_v = bit_v >> 2;
          while (bit_v != 0) begin
            if (ratio >= res + bit_v) begin
              ratio = ratio - (res + bit_v);
              res = (res >> 1) + bit_v;
            end else begin
              res = res >> 1;
            end
            bit_v = bit_v >> 2;
          end
          s = res;
          for (int i = 0; i < 3; i++) begin
            prod = {64'd0, mag64(ev[i])} * {64'd0, s};
            ev[i] = ev[i] < 0 ? -$signed(prod[94:31]) : $signed(prod[94:31]);
          end
          r.scaled = 1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (ev[i] > 64'sd2147483647) ev[i] = 64'sd2147483647;
      if (ev[i] < -64'sd2147483648) ev[i] = -64'sd2147483648;
    end
    r.ex = ev[0][31:0];
    r.ey = ev[1][31:0];
    r.ez = ev[2][31:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    limit_on = 1;
  end

  always @(posedge clk) begin
    field_t exp_f;
    logic signed [31:0] bi[3], ei[3];
    if (rst) begin
      limit_on = 1;
    end else begin
      if (cfg_valid && cfg_ready) limit_on = cfg_data;
      if (in_valid && in_ready) begin
        bi[0] = b_x; bi[1] = b_y; bi[2] = b_z;
        ei[0] = e_x; ei[1] = e_y; ei[2] = e_z;
        corrected_q.push_back(correct_field(bi, ei, limit_on));
      end
      if (out_valid && out_ready) begin
        if (corrected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          exp_f = corrected_q.pop_front();
          if (new_e_x !== exp_f.ex) begin
            $error("new_e_x expected %0d actual %0d", exp_f.ex, new_e_x);
            errors++;
          end
          if (new_e_y !== exp_f.ey) begin
            $error("new_e_y expected %0d actual %0d", exp_f.ey, new_e_y);
            errors++;
          end
          if (new_e_z !== exp_f.ez) begin
            $error("new_e_z expected %0d actual %0d", exp_f.ez, new_e_z);
            errors++;
          end
          if (was_scaled !== exp_f.scaled) begin
            $error("was_scaled expected %0b actual %0b", exp_f.scaled, was_scaled);
            errors++;
          end
          if (null_field !== exp_f.nul) begin
            $error("null_field expected %0b actual %0b", exp_f.nul, null_field);
            errors++;
          end
        end
      end
    end
    pending = corrected_q.size();
  end
endmodule

// File: tb/testbench.sv
// Top of the force-free field correction testbench: clock, reset, directed
// and random cell stimulus, limit-register writes and the verdict.
// Depends on force_free_e_field_correction and ffc_checker.
module testbench;
  localparam int DRAIN = 250;
  localparam int STALL_LIMIT = 4000;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] b_x = 0, b_y = 0, b_z = 0, e_x = 0, e_y = 0, e_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] new_e_x, new_e_y, new_e_z;
  logic was_scaled, null_field;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_data = 0;
  int errors, pending;
  int send_idle = 0, recv_stall = 0;
  int quiet_cycles = 0;

  force_free_e_field_correction u_top (.*);

  ffc_checker u_checker (.*);

  initial forever #2 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_cell(logic signed [31:0] bx, by, bz, ex, ey, ez);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    {b_x, b_y, b_z, e_x, e_y, e_z} <= {bx, by, bz, ex, ey, ez};
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_limit(logic v);
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: case ($urandom_range(4))
           0: return MAXV;
           1: return MINV;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      1, 2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
    endcase
  endfunction

  task automatic directed_cells();
    send_cell(0, 0, 0, 0, 0, 0);
    send_cell(0, 0, 0, MAXV, MINV, -1);
    send_cell(ONE, 0, 0, 2 * ONE, 3 * ONE, 4 * ONE);
    send_cell(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_cell(MINV, MINV, MINV, MINV, MINV, MINV);
    send_cell(MINV, MINV, MINV, MAXV, MINV, MAXV);
    send_cell(ONE, 0, 0, 0, MAXV, MINV);
    send_cell(-1, 1, -1, MAXV, MINV, MAXV);
    send_cell(1, 0, 0, MINV, MINV, MINV);
    send_cell(ONE, ONE, 0, 0, 0, 0);
    send_cell(ONE, -ONE, ONE, 5 * ONE, -5 * ONE, 5 * ONE);
    send_cell(MAXV, 0, MINV, 1, -1, 1);
  endtask

  task automatic random_cells(int n);
    logic signed [31:0] bx, by, bz;
    int k;
    repeat (n) begin
      if ($urandom_range(19) == 0) begin
        bx = 0; by = 0; bz = 0;
      end else begin
        bx = pick_value(); by = pick_value(); bz = pick_value();
      end
      if ($urandom_range(7) == 0) begin
        k = $urandom_range(0, 7) - 3;
        send_cell(bx, by, bz, bx * k + pick_value() % 64, by * k, bz * k);
      end else begin
        send_cell(bx, by, bz, pick_value(), pick_value(), pick_value());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    directed_cells();
    write_limit(0);
    directed_cells();
    send_idle = 13;
    recv_stall = 74;
    random_cells(450);
    write_limit(1);
    send_idle = 74;
    recv_stall = 13;
    random_cells(550);
    write_limit(0);
    write_limit(1);
    send_idle = 0;
    recv_stall = 0;
    random_cells(600);
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
